FILE: src/gnd_pkg.sv
// Shared types and sizes for the grid niche density objective block.
// Has no dependencies; the top level and gnd_div refer to it by scoped names.
package gnd_pkg;

	localparam int MaxPopulation = 64;
	localparam int MaxDimensions = 16;
	localparam int StoreDepth    = MaxPopulation * MaxDimensions;
	localparam int DistDepth     = MaxPopulation * MaxPopulation;
	localparam int DivNumW       = 42;
	localparam int DivDenW       = 33;
	localparam int DivCntW       = 6;

	localparam logic [1:0] CfgNum = 2'd0;
	localparam logic [1:0] CfgDim = 2'd1;
	localparam logic [1:0] CfgGen = 2'd2;

	typedef struct packed {
		logic signed [31:0] coordinate;
		logic [15:0]        generation;
		logic               last_coordinate;
	} request_t;

	typedef struct packed {
		logic [5:0]         individual_index;
		logic signed [15:0] density_objective;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic                 start;
		logic [DivNumW-1:0]   num;
		logic [DivDenW-1:0]   den;
	} div_req_t;

endpackage

FILE: src/grid_niche_density_objective.sv
// Top level of the grid niche density objective block.
// Depends on gnd_pkg, gnd_ram and gnd_div.
//
// Coordinates are taken one per cycle while busy is low and written straight
// into the coordinate memory. The request marked as the last coordinate raises
// busy, and the block then works through the population from its memories:
// the per-dimension range, the grid cells (set by the bit-serial divider),
// the distance table, then delta, and then each individual in turn (with no
// divide when the density denominator is zero), each ending in one result
// strobe. Results cannot be held off and come in individual order; busy drops
// in the same cycle as the last result strobe.
module grid_niche_density_objective (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gnd_pkg::request_t   request,
	output logic                result_valid,
	output gnd_pkg::result_t    result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_MM_RD   = 5'd1;
	localparam logic [4:0] S_MM_UP   = 5'd2;
	localparam logic [4:0] S_GR_RD   = 5'd3;
	localparam logic [4:0] S_GR_MUL  = 5'd4;
	localparam logic [4:0] S_GR_DIV  = 5'd5;
	localparam logic [4:0] S_GR_WAIT = 5'd6;
	localparam logic [4:0] S_RW_RD   = 5'd7;
	localparam logic [4:0] S_RW_WR   = 5'd8;
	localparam logic [4:0] S_DS_RD   = 5'd9;
	localparam logic [4:0] S_DS_ACC  = 5'd10;
	localparam logic [4:0] S_DS_WR   = 5'd11;
	localparam logic [4:0] S_DEN     = 5'd12;
	localparam logic [4:0] S_OB_RD   = 5'd13;
	localparam logic [4:0] S_OB_MUL  = 5'd14;
	localparam logic [4:0] S_OB_ACC  = 5'd15;
	localparam logic [4:0] S_OB_NUM  = 5'd16;
	localparam logic [4:0] S_OB_DIV  = 5'd17;
	localparam logic [4:0] S_OB_WAIT = 5'd18;
	localparam logic [4:0] S_OB_OUT  = 5'd19;

	logic [6:0]  num_ind_q;
	logic [4:0]  num_dim_q;
	logic [15:0] gen_limit_q;

	logic [4:0]  state_q;
	logic [9:0]  load_pos_q;
	logic [5:0]  i_q;
	logic [5:0]  k_q;
	logic [3:0]  j_q;
	logic [15:0] t_q;
	logic signed [31:0] mn_q [gnd_pkg::MaxDimensions];
	logic signed [31:0] mx_q [gnd_pkg::MaxDimensions];
	logic [6:0]  row_q [gnd_pkg::MaxDimensions];
	logic [9:0]  acc_q;
	logic [9:0]  best_q;
	logic [9:0]  radius_q;
	logic [38:0] mulg_q;
	logic [32:0] span_q;
	logic [26:0] den_q;
	logic        den_zero_q;
	logic [25:0] dprod_q;
	logic [9:0]  dval_q;
	logic [15:0] sum_q;
	logic [6:0]  cnt_q;
	logic [31:0] sumt_q;
	logic        res_valid_q;
	gnd_pkg::result_t res_q;

	logic [6:0]  n_eff;
	logic [4:0]  d_eff;
	logic [5:0]  nm1;
	logic [3:0]  dm1;
	logic [15:0] tmax;
	logic [10:0] total;
	logic [9:0]  pos_eff;
	logic [10:0] pos_inc;
	logic        accept;

	logic        c_we;
	logic [9:0]  c_raddr;
	logic [31:0] c_rdata;
	logic        g_we;
	logic [9:0]  g_waddr;
	logic [6:0]  g_wdata;
	logic [9:0]  g_raddr;
	logic [6:0]  g_rdata;
	logic        d_we;
	logic [11:0] d_raddr;
	logic [9:0]  d_rdata;

	logic [10:0] row_base;
	logic [32:0] diff_w;
	logic [32:0] span_w;
	logic [6:0]  absd;
	logic [9:0]  acc_next;
	logic [9:0]  best_next;
	logic [17:0] span_t;
	logic        span_pos;
	logic [41:0] quo;
	logic        div_done;
	logic [16:0] q_clip;
	logic signed [17:0] obj_w;
	logic signed [15:0] obj_sat;
	gnd_pkg::div_req_t div_req;

	always_comb begin
		n_eff = num_ind_q;
		if (num_ind_q < 7'd2) begin
			n_eff = 7'd2;
		end else if (num_ind_q > 7'(gnd_pkg::MaxPopulation)) begin
			n_eff = 7'(gnd_pkg::MaxPopulation);
		end
		d_eff = num_dim_q;
		if (num_dim_q < 5'd1) begin
			d_eff = 5'd1;
		end else if (num_dim_q > 5'(gnd_pkg::MaxDimensions)) begin
			d_eff = 5'(gnd_pkg::MaxDimensions);
		end
	end

	assign nm1     = 6'(n_eff - 7'd1);
	assign dm1     = 4'(d_eff - 5'd1);
	assign tmax    = (gen_limit_q == 16'd0) ? 16'd1 : gen_limit_q;
	assign total   = 11'(n_eff) * 11'(d_eff);
	assign pos_eff = ({1'b0, load_pos_q} >= total) ? 10'd0 : load_pos_q;
	assign pos_inc = {1'b0, pos_eff} + 11'd1;
	assign busy    = state_q != S_IDLE;
	assign accept  = start && !busy;

	assign row_base = 11'(i_q) * 11'(d_eff) + 11'(j_q);
	assign c_we     = accept;
	assign c_raddr  = row_base[9:0];

	assign diff_w = {c_rdata[31], c_rdata} - {mn_q[j_q][31], mn_q[j_q]};
	assign span_w = {mx_q[j_q][31], mx_q[j_q]} - {mn_q[j_q][31], mn_q[j_q]};

	assign absd      = (row_q[j_q] > g_rdata) ? row_q[j_q] - g_rdata : g_rdata - row_q[j_q];
	assign acc_next  = acc_q + 10'(absd);
	assign best_next = (k_q != i_q && acc_q < best_q) ? acc_q : best_q;

	assign span_t   = {2'b0, tmax} + 18'd1 - {2'b0, t_q};
	assign span_pos = !span_t[17] && span_t != 18'd0;

	assign g_raddr = (state_q == S_RW_RD) ? {i_q, j_q} : {k_q, j_q};
	assign d_raddr = {i_q, k_q};
	assign d_we    = state_q == S_DS_WR;

	always_comb begin
		g_we    = 1'b0;
		g_waddr = {i_q, j_q};
		g_wdata = 7'd1;
		if (state_q == S_GR_DIV && span_q == 33'd0) begin
			g_we = 1'b1;
		end else if (state_q == S_GR_WAIT && div_done) begin
			g_we    = 1'b1;
			g_wdata = quo[6:0] + 7'd1;
		end
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = {3'b0, mulg_q};
		div_req.den   = span_q;
		if (state_q == S_GR_DIV && span_q != 33'd0) begin
			div_req.start = 1'b1;
		end else if (state_q == S_OB_DIV) begin
			div_req.start = 1'b1;
			div_req.num   = {1'b0, sumt_q, 9'b0} + {15'b0, den_q};
			div_req.den   = {5'b0, den_q, 1'b0};
		end
	end

	always_comb begin
		q_clip = (quo > 42'd32768) ? 17'd32768 : quo[16:0];
		obj_w  = $signed({1'b0, q_clip}) - $signed({3'b0, cnt_q, 8'b0});
		if (obj_w > 18'sd16384) begin
			obj_sat = 16'sd16384;
		end else if (obj_w < -18'sd16384) begin
			obj_sat = -16'sd16384;
		end else begin
			obj_sat = obj_w[15:0];
		end
	end

	gnd_ram #(.Width(32), .Depth(gnd_pkg::StoreDepth)) u_coord_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (pos_eff),
		.wdata (request.coordinate),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	gnd_ram #(.Width(7), .Depth(gnd_pkg::StoreDepth)) u_grid_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	gnd_ram #(.Width(10), .Depth(gnd_pkg::DistDepth)) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr ({i_q, k_q}),
		.wdata (acc_q),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	gnd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ind_q   <= 7'd64;
			num_dim_q   <= 5'd2;
			gen_limit_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				gnd_pkg::CfgNum: num_ind_q   <= cfg_data[6:0];
				gnd_pkg::CfgDim: num_dim_q   <= cfg_data[4:0];
				gnd_pkg::CfgGen: gen_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			load_pos_q  <= '0;
			radius_q    <= '0;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (request.last_coordinate) begin
							load_pos_q <= '0;
							radius_q   <= '0;
							i_q        <= '0;
							j_q        <= '0;
							state_q    <= S_MM_RD;
						end else begin
							load_pos_q <= (pos_inc >= total) ? 10'd0 : pos_inc[9:0];
						end
					end
				end
				S_MM_RD: state_q <= S_MM_UP;
				S_MM_UP: begin
					if (i_q == nm1) begin
						i_q <= '0;
						if (j_q == dm1) begin
							j_q     <= '0;
							state_q <= S_GR_RD;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_MM_RD;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_MM_RD;
					end
				end
				S_GR_RD:  state_q <= S_GR_MUL;
				S_GR_MUL: state_q <= S_GR_DIV;
				S_GR_DIV, S_GR_WAIT: begin
					if (g_we) begin
						if (j_q == dm1) begin
							j_q <= '0;
							if (i_q == nm1) begin
								i_q     <= '0;
								state_q <= S_RW_RD;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= S_GR_RD;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_GR_RD;
						end
					end else begin
						state_q <= S_GR_WAIT;
					end
				end
				S_RW_RD: state_q <= S_RW_WR;
				S_RW_WR: begin
					if (j_q == dm1) begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= S_DS_RD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RW_RD;
					end
				end
				S_DS_RD: state_q <= S_DS_ACC;
				S_DS_ACC: begin
					if (j_q == dm1) begin
						j_q     <= '0;
						state_q <= S_DS_WR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_DS_RD;
					end
				end
				S_DS_WR: begin
					if (k_q == nm1) begin
						k_q <= '0;
						if (best_next > radius_q) begin
							radius_q <= best_next;
						end
						if (i_q == nm1) begin
							i_q     <= '0;
							state_q <= S_DEN;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RW_RD;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DS_RD;
					end
				end
				S_DEN:    state_q <= S_OB_RD;
				S_OB_RD:  state_q <= S_OB_MUL;
				S_OB_MUL: state_q <= S_OB_ACC;
				S_OB_ACC: begin
					if (k_q == nm1) begin
						k_q     <= '0;
						state_q <= S_OB_NUM;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_OB_RD;
					end
				end
				S_OB_NUM: state_q <= den_zero_q ? S_OB_OUT : S_OB_DIV;
				S_OB_DIV: state_q <= S_OB_WAIT;
				S_OB_WAIT: begin
					if (div_done) begin
						state_q <= S_OB_OUT;
					end
				end
				S_OB_OUT: begin
					res_valid_q <= 1'b1;
					if (i_q == nm1) begin
						i_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_OB_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q <= request.generation;
			end
			S_MM_UP: begin
				if (i_q == 6'd0 || $signed(c_rdata) < mn_q[j_q]) begin
					mn_q[j_q] <= $signed(c_rdata);
				end
				if (i_q == 6'd0 || $signed(c_rdata) > mx_q[j_q]) begin
					mx_q[j_q] <= $signed(c_rdata);
				end
			end
			S_GR_MUL: begin
				mulg_q <= 39'(nm1) * 39'(diff_w);
				span_q <= span_w;
			end
			S_RW_WR: begin
				row_q[j_q] <= g_rdata;
				acc_q      <= '0;
				best_q     <= '1;
			end
			S_DS_ACC: begin
				acc_q <= acc_next;
			end
			S_DS_WR: begin
				acc_q  <= '0;
				best_q <= best_next;
			end
			S_DEN: begin
				den_q      <= span_pos ? 27'(radius_q) * 27'(span_t[16:0]) : 27'd0;
				den_zero_q <= !span_pos || radius_q == 10'd0;
				sum_q      <= '0;
				cnt_q      <= '0;
			end
			S_OB_MUL: begin
				dprod_q <= 26'(d_rdata) * 26'(tmax);
				dval_q  <= d_rdata;
			end
			S_OB_ACC: begin
				if ({1'b0, dprod_q} < den_q) begin
					sum_q <= sum_q + 16'(dval_q);
					cnt_q <= cnt_q + 7'd1;
				end
			end
			S_OB_NUM: begin
				sumt_q <= 32'(sum_q) * 32'(tmax);
			end
			S_OB_OUT: begin
				res_q.individual_index  <= i_q;
				res_q.density_objective <= den_zero_q ? 16'sd0 : obj_sat;
				res_q.last_result       <= i_q == nm1;
				sum_q                   <= '0;
				cnt_q                   <= '0;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: src/gnd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the address. No package dependencies.
module gnd_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/gnd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gnd_pkg for widths and the request struct.
module gnd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gnd_pkg::div_req_t             req,
	output logic                          done,
	output logic [gnd_pkg::DivNumW-1:0]   quotient
);

	logic [gnd_pkg::DivDenW-1:0] rem_q;
	logic [gnd_pkg::DivDenW-1:0] den_q;
	logic [gnd_pkg::DivNumW-1:0] quo_q;
	logic [gnd_pkg::DivCntW-1:0] cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [gnd_pkg::DivDenW:0]   cand;
	logic                        ge;

	assign cand = {rem_q, quo_q[gnd_pkg::DivNumW-1]};
	assign ge   = cand >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == gnd_pkg::DivCntW'(gnd_pkg::DivNumW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= gnd_pkg::DivDenW'(cand - {1'b0, den_q});
			end else begin
				rem_q <= cand[gnd_pkg::DivDenW-1:0];
			end
			quo_q <= {quo_q[gnd_pkg::DivNumW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
